### rtl/spst_pkg.sv
package spst_pkg;

    localparam logic [1:0] OP_SPRITE = 2'd0;
    localparam logic [1:0] OP_FRAME  = 2'd1;
    localparam logic [1:0] OP_RUN    = 2'd2;
    localparam logic [1:0] OP_READ   = 2'd3;

    localparam logic [2:0] CFG_ADD_TO_INPUT  = 3'd0;
    localparam logic [2:0] CFG_COLORIZE      = 3'd1;
    localparam logic [2:0] CFG_MAX_PARTICLES = 3'd2;
    localparam logic [2:0] CFG_FRAME_WIDTH   = 3'd3;
    localparam logic [2:0] CFG_FRAME_HEIGHT  = 3'd4;
    localparam logic [2:0] CFG_SPRITE_WIDTH  = 3'd5;
    localparam logic [2:0] CFG_SPRITE_HEIGHT = 3'd6;

    localparam int CFG_DW = 11;

    typedef struct packed {
        logic load_sprite;
        logic load_frame;
        logic read_issue;
        logic resp_load;
        logic run_start;
        logic scan_start;
        logic frame_rd;
        logic copy_wr;
        logic pix_adv;
        logic stamp_init;
        logic stamp_rd;
        logic stamp_wr;
        logic stamp_adv;
        logic placed_inc;
    } cmd_t;

    typedef struct packed {
        logic pix_last;
        logic pix_lit;
        logic st_last;
        logic st_inb;
        logic placed_full;
    } sts_t;

endpackage

### rtl/spst_ctrl.sv
module spst_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    output logic               out_valid,
    input  logic               out_stall,
    input  spst_pkg::sts_t     sts,
    output spst_pkg::cmd_t     cmd
);

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_RESP  = 9'b000000010,
        ST_C_RD  = 9'b000000100,
        ST_C_WR  = 9'b000001000,
        ST_S_RD  = 9'b000010000,
        ST_S_CHK = 9'b000100000,
        ST_T_RD  = 9'b001000000,
        ST_T_WR  = 9'b010000000,
        ST_T_END = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   accept;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (opcode)
                        spst_pkg::OP_SPRITE: cmd.load_sprite = 1'b1;
                        spst_pkg::OP_FRAME:  cmd.load_frame  = 1'b1;
                        spst_pkg::OP_RUN:
                        begin
                            cmd.run_start = 1'b1;
                            state_next    = ST_C_RD;
                        end
                        spst_pkg::OP_READ:
                        begin
                            cmd.read_issue = 1'b1;
                            state_next     = ST_RESP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RESP:
            begin
                cmd.resp_load = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_C_RD:
            begin
                cmd.frame_rd = 1'b1;
                state_next   = ST_C_WR;
            end
            ST_C_WR:
            begin
                cmd.copy_wr = 1'b1;
                if (sts.pix_last)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_S_RD;
                end
                else
                begin
                    cmd.pix_adv = 1'b1;
                    state_next  = ST_C_RD;
                end
            end
            ST_S_RD:
            begin
                cmd.frame_rd = 1'b1;
                state_next   = ST_S_CHK;
            end
            ST_S_CHK:
            begin
                if (sts.pix_lit)
                begin
                    cmd.stamp_init = 1'b1;
                    state_next     = ST_T_RD;
                end
                else if (sts.pix_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.pix_adv = 1'b1;
                    state_next  = ST_S_RD;
                end
            end
            ST_T_RD:
            begin
                if (sts.st_inb)
                begin
                    cmd.stamp_rd = 1'b1;
                    state_next   = ST_T_WR;
                end
                else
                begin
                    cmd.stamp_adv = 1'b1;
                    if (sts.st_last)
                        state_next = ST_T_END;
                end
            end
            ST_T_WR:
            begin
                cmd.stamp_wr  = 1'b1;
                cmd.stamp_adv = 1'b1;
                state_next    = sts.st_last ? ST_T_END : ST_T_RD;
            end
            ST_T_END:
            begin
                cmd.placed_inc = 1'b1;
                if (sts.placed_full || sts.pix_last)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.pix_adv = 1'b1;
                    state_next  = ST_S_RD;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (state_reg == ST_RESP)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### rtl/spst_dp.sv
module spst_dp
#(
    parameter int MAX_FRAME_W  = 256,
    parameter int MAX_FRAME_H  = 256,
    parameter int MAX_SPRITE_W = 32,
    parameter int MAX_SPRITE_H = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [spst_pkg::CFG_DW-1:0] cfg_data,
    input  logic [7:0]                  pos_x,
    input  logic [7:0]                  pos_y,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    output logic [7:0]                  out_red,
    output logic [7:0]                  out_green,
    output logic [7:0]                  out_blue,
    input  spst_pkg::cmd_t              cmd,
    output spst_pkg::sts_t              sts
);

    localparam int FXW = (MAX_FRAME_W  > 1) ? $clog2(MAX_FRAME_W)  : 1;
    localparam int FYW = (MAX_FRAME_H  > 1) ? $clog2(MAX_FRAME_H)  : 1;
    localparam int SXW = (MAX_SPRITE_W > 1) ? $clog2(MAX_SPRITE_W) : 1;
    localparam int SYW = (MAX_SPRITE_H > 1) ? $clog2(MAX_SPRITE_H) : 1;
    localparam int CXW = ((FXW > SXW) ? FXW : SXW) + 2;
    localparam int CYW = ((FYW > SYW) ? FYW : SYW) + 2;
    localparam int FDEPTH = 1 << (FXW + FYW);
    localparam int SDEPTH = 1 << (SXW + SYW);

    logic        add_reg;
    logic        colorize_reg;
    logic [10:0] maxp_reg;
    logic [8:0]  fw_reg;
    logic [8:0]  fh_reg;
    logic [5:0]  sw_reg;
    logic [5:0]  sh_reg;

    logic [23:0] smem [SDEPTH];
    logic [23:0] imem [FDEPTH];
    logic [23:0] omem [FDEPTH];

    logic [23:0] srd_reg;
    logic [23:0] ird_reg;
    logic [23:0] ord_reg;
    logic        oor_reg;
    logic [23:0] tint_reg;
    logic [7:0]  ored_reg, ogreen_reg, oblue_reg;

    logic [FXW-1:0] x_reg, cx_reg;
    logic [FYW-1:0] y_reg, cy_reg;
    logic [SXW-1:0] ix_reg;
    logic [SYW-1:0] iy_reg;
    logic [10:0]    placed_reg;

    logic [FXW:0]   fw_eff;
    logic [FYW:0]   fh_eff;
    logic [SXW:0]   sw_eff;
    logic [SYW:0]   sh_eff;
    logic [10:0]    maxp_eff;
    logic           x_last, y_last, ix_last, iy_last;
    logic [CXW-1:0] fx;
    logic [CYW-1:0] fy;
    logic           fx_ok, fy_ok;
    logic [23:0]    pix_in;
    logic [23:0]    stamp_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            add_reg      <= 1'b0;
            colorize_reg <= 1'b0;
            maxp_reg     <= 11'd1;
            fw_reg       <= 9'd256;
            fh_reg       <= 9'd256;
            sw_reg       <= 6'd21;
            sh_reg       <= 6'd21;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spst_pkg::CFG_ADD_TO_INPUT:  add_reg      <= cfg_data[0];
                spst_pkg::CFG_COLORIZE:      colorize_reg <= cfg_data[0];
                spst_pkg::CFG_MAX_PARTICLES: maxp_reg     <= cfg_data[10:0];
                spst_pkg::CFG_FRAME_WIDTH:   fw_reg       <= cfg_data[8:0];
                spst_pkg::CFG_FRAME_HEIGHT:  fh_reg       <= cfg_data[8:0];
                spst_pkg::CFG_SPRITE_WIDTH:  sw_reg       <= cfg_data[5:0];
                spst_pkg::CFG_SPRITE_HEIGHT: sh_reg       <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        if (fw_reg == 9'd0)
            fw_eff = (FXW+1)'(1);
        else if (32'(fw_reg) > MAX_FRAME_W)
            fw_eff = (FXW+1)'(MAX_FRAME_W);
        else
            fw_eff = (FXW+1)'(fw_reg);
        if (fh_reg == 9'd0)
            fh_eff = (FYW+1)'(1);
        else if (32'(fh_reg) > MAX_FRAME_H)
            fh_eff = (FYW+1)'(MAX_FRAME_H);
        else
            fh_eff = (FYW+1)'(fh_reg);
        if (sw_reg == 6'd0)
            sw_eff = (SXW+1)'(1);
        else if (32'(sw_reg) > MAX_SPRITE_W)
            sw_eff = (SXW+1)'(MAX_SPRITE_W);
        else
            sw_eff = (SXW+1)'(sw_reg);
        if (sh_reg == 6'd0)
            sh_eff = (SYW+1)'(1);
        else if (32'(sh_reg) > MAX_SPRITE_H)
            sh_eff = (SYW+1)'(MAX_SPRITE_H);
        else
            sh_eff = (SYW+1)'(sh_reg);
        maxp_eff = (maxp_reg == 11'd0) ? 11'd1 : maxp_reg;
    end

    assign x_last  = ({1'b0, x_reg} + 1'b1) == fw_eff;
    assign y_last  = ({1'b0, y_reg} + 1'b1) == fh_eff;
    assign ix_last = ({1'b0, ix_reg} + 1'b1) == sw_eff;
    assign iy_last = ({1'b0, iy_reg} + 1'b1) == sh_eff;

    assign fx = CXW'(cx_reg) + CXW'(ix_reg) - CXW'(sw_eff >> 1);
    assign fy = CYW'(cy_reg) + CYW'(iy_reg) - CYW'(sh_eff >> 1);
    assign fx_ok = !fx[CXW-1] && (fx < CXW'(fw_eff));
    assign fy_ok = !fy[CYW-1] && (fy < CYW'(fh_eff));

    assign sts.pix_last    = x_last && y_last;
    assign sts.pix_lit     = ird_reg != 24'd0;
    assign sts.st_last     = ix_last && iy_last;
    assign sts.st_inb      = fx_ok && fy_ok;
    assign sts.placed_full = ({1'b0, placed_reg} + 12'd1) >= {1'b0, maxp_eff};

    assign pix_in = {red, green, blue};

    // sprite and input frame stores
    always_ff @(posedge clk)
    begin
        if (cmd.load_sprite && 32'(pos_x) < MAX_SPRITE_W && 32'(pos_y) < MAX_SPRITE_H)
            smem[{SYW'(pos_y), SXW'(pos_x)}] <= pix_in;
        if (cmd.stamp_rd)
            srd_reg <= smem[{iy_reg, ix_reg}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_frame && 32'(pos_x) < MAX_FRAME_W && 32'(pos_y) < MAX_FRAME_H)
            imem[{FYW'(pos_y), FXW'(pos_x)}] <= pix_in;
        if (cmd.frame_rd)
            ird_reg <= imem[{y_reg, x_reg}];
    end

    // stamp pixel: optional tint, then saturating add
    always_comb
    begin
        logic [7:0]  sc [3];
        logic [15:0] prod;
        logic [8:0]  sum;
        for (int c = 0; c < 3; c++)
        begin
            sc[c] = srd_reg[8*c +: 8];
            prod  = sc[c] * tint_reg[8*c +: 8];
            if (colorize_reg)
                sc[c] = prod[15:8];
            sum = {1'b0, ord_reg[8*c +: 8]} + {1'b0, sc[c]};
            stamp_pix[8*c +: 8] = sum[8] ? 8'd255 : sum[7:0];
        end
    end

    // output frame store
    always_ff @(posedge clk)
    begin
        if (cmd.copy_wr)
            omem[{y_reg, x_reg}] <= add_reg ? ird_reg : 24'd0;
        else if (cmd.stamp_wr)
            omem[{fy[FYW-1:0], fx[FXW-1:0]}] <= stamp_pix;
        if (cmd.read_issue)
            ord_reg <= omem[{FYW'(pos_y), FXW'(pos_x)}];
        else if (cmd.stamp_rd)
            ord_reg <= omem[{fy[FYW-1:0], fx[FXW-1:0]}];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read_issue)
            oor_reg <= !(32'(pos_x) < MAX_FRAME_W && 32'(pos_y) < MAX_FRAME_H);
        if (cmd.resp_load)
        begin
            ored_reg   <= oor_reg ? 8'd0 : ord_reg[23:16];
            ogreen_reg <= oor_reg ? 8'd0 : ord_reg[15:8];
            oblue_reg  <= oor_reg ? 8'd0 : ord_reg[7:0];
        end
        if (cmd.stamp_init)
        begin
            tint_reg <= ird_reg;
            cx_reg   <= x_reg;
            cy_reg   <= y_reg;
        end
    end

    assign out_red   = ored_reg;
    assign out_green = ogreen_reg;
    assign out_blue  = oblue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            ix_reg     <= '0;
            iy_reg     <= '0;
            placed_reg <= '0;
        end
        else
        begin
            if (cmd.run_start || cmd.scan_start)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            else if (cmd.pix_adv)
            begin
                if (x_last)
                begin
                    x_reg <= '0;
                    y_reg <= y_reg + 1'b1;
                end
                else
                    x_reg <= x_reg + 1'b1;
            end
            if (cmd.scan_start)
                placed_reg <= '0;
            else if (cmd.placed_inc)
                placed_reg <= placed_reg + 1'b1;
            if (cmd.stamp_init)
            begin
                ix_reg <= '0;
                iy_reg <= '0;
            end
            else if (cmd.stamp_adv)
            begin
                if (ix_last)
                begin
                    ix_reg <= '0;
                    iy_reg <= iy_reg + 1'b1;
                end
                else
                    ix_reg <= ix_reg + 1'b1;
            end
        end
    end

endmodule

### rtl/sprite_stamp_on_lit_pixels.sv
// loads (opcodes 0, 1) are accepted back to back while no read response is waiting
// a read (opcode 3) registers its word, then shows it from the output registers; next item after it is taken
// a run copies (or clears) every output pixel, then scans the input frame and stamps the sprite
// centred on each lit pixel, skipping clipped sprite pixels, until the particle limit or the last pixel is reached
// reset clears control state and loads register defaults; the stores are not cleared
module sprite_stamp_on_lit_pixels
#(
    parameter int MAX_FRAME_W  = 256,
    parameter int MAX_FRAME_H  = 256,
    parameter int MAX_SPRITE_W = 32,
    parameter int MAX_SPRITE_H = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  opcode,
    input  logic [7:0]                  pos_x,
    input  logic [7:0]                  pos_y,
    input  logic [7:0]                  red,
    input  logic [7:0]                  green,
    input  logic [7:0]                  blue,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [7:0]                  out_red,
    output logic [7:0]                  out_green,
    output logic [7:0]                  out_blue,
    input  logic                        cfg_we,
    input  logic [2:0]                  cfg_index,
    input  logic [spst_pkg::CFG_DW-1:0] cfg_data
);

    spst_pkg::cmd_t cmd;
    spst_pkg::sts_t sts;

    spst_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    spst_dp
    #(
        .MAX_FRAME_W  (MAX_FRAME_W),
        .MAX_FRAME_H  (MAX_FRAME_H),
        .MAX_SPRITE_W (MAX_SPRITE_W),
        .MAX_SPRITE_H (MAX_SPRITE_H)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
